@@ src/alu8_pkg.sv @@
// Package for the eight-bit ALU: operation codes, flag positions and transfer structs.
package alu8_pkg;

  typedef enum logic [3:0] {
    OP_ADC  = 4'd0,
    OP_SBC  = 4'd1,
    OP_AND  = 4'd2,
    OP_ORA  = 4'd3,
    OP_EOR  = 4'd4,
    OP_CMP  = 4'd5,
    OP_BIT  = 4'd6,
    OP_ASL  = 4'd7,
    OP_LSR  = 4'd8,
    OP_ROL  = 4'd9,
    OP_ROR  = 4'd10,
    OP_INC  = 4'd11,
    OP_DEC  = 4'd12,
    OP_LOAD = 4'd13
  } op_e;

  // Status byte bit positions
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  typedef struct packed {
    logic [3:0] operation;
    logic [7:0] reg_operand;
    logic [7:0] mem_value;
    logic [7:0] status_in;
  } alu_in_t;

  typedef struct packed {
    logic [7:0] result;
    logic       result_write;
    logic [7:0] status_out;
  } alu_out_t;

endpackage

@@ src/eight_bit_alu_with_flags.sv @@
// Eight-bit ALU with 6502-style status flags, one operation per clock.
//
//   channel  | direction | transfer when         | payload
//   ---------+-----------+-----------------------+---------------------
//   command  | in        | start && !busy        | item_i   (alu_in_t)
//   result   | out       | res_valid_o           | res_o    (alu_out_t)
//
// A command passes through the input register and then the result register.
// A new command can be taken every cycle; busy stays low.
// Reset clears both valid stages; payload registers are not reset.
// The result strobe lasts one cycle and cannot be stalled.
module eight_bit_alu_with_flags (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  alu8_pkg::alu_in_t  item_i,
  output logic               res_valid_o,
  output alu8_pkg::alu_out_t res_o
);

  logic               in_valid_q;
  alu8_pkg::alu_in_t  in_q;
  logic               res_valid_q;
  alu8_pkg::alu_out_t res_q, res_d;

  logic       accept;
  logic [7:0] a, m, st, r;
  logic       cin, wr;
  logic [7:0] add_b;
  logic [8:0] add_sum;
  logic [8:0] cmp_diff;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign a   = in_q.reg_operand;
  assign m   = in_q.mem_value;
  assign cin = in_q.status_in[alu8_pkg::FlagC];

  // SBC is A + ~M + C; carry out means no borrow
  assign add_b    = (alu8_pkg::op_e'(in_q.operation) == alu8_pkg::OP_SBC) ? ~m : m;
  assign add_sum  = {1'b0, a} + {1'b0, add_b} + {8'd0, cin};
  assign cmp_diff = {1'b0, a} + {1'b0, ~m} + 9'd1;

  always_comb begin
    st = in_q.status_in;
    r  = 8'd0;
    wr = 1'b1;
    unique case (alu8_pkg::op_e'(in_q.operation))
      alu8_pkg::OP_ADC, alu8_pkg::OP_SBC: begin
        r = add_sum[7:0];
        st[alu8_pkg::FlagC] = add_sum[8];
        st[alu8_pkg::FlagV] = ~(a[7] ^ add_b[7]) & (a[7] ^ add_sum[7]);
      end
      alu8_pkg::OP_AND:  r = a & m;
      alu8_pkg::OP_ORA:  r = a | m;
      alu8_pkg::OP_EOR:  r = a ^ m;
      alu8_pkg::OP_CMP: begin
        wr = 1'b0;
      end
      alu8_pkg::OP_BIT: begin
        wr = 1'b0;
      end
      alu8_pkg::OP_ASL: begin
        r = {m[6:0], 1'b0};
        st[alu8_pkg::FlagC] = m[7];
      end
      alu8_pkg::OP_LSR: begin
        r = {1'b0, m[7:1]};
        st[alu8_pkg::FlagC] = m[0];
      end
      alu8_pkg::OP_ROL: begin
        r = {m[6:0], cin};
        st[alu8_pkg::FlagC] = m[7];
      end
      alu8_pkg::OP_ROR: begin
        r = {cin, m[7:1]};
        st[alu8_pkg::FlagC] = m[0];
      end
      alu8_pkg::OP_INC:  r = m + 8'd1;
      alu8_pkg::OP_DEC:  r = m - 8'd1;
      alu8_pkg::OP_LOAD: r = m;
      default: begin
        wr = 1'b0;
      end
    endcase

    // N/Z: compare and BIT have their own rules, undefined codes leave flags alone
    if (alu8_pkg::op_e'(in_q.operation) == alu8_pkg::OP_CMP) begin
      st[alu8_pkg::FlagC] = cmp_diff[8];
      st[alu8_pkg::FlagZ] = (a == m);
      st[alu8_pkg::FlagN] = cmp_diff[7];
    end else if (alu8_pkg::op_e'(in_q.operation) == alu8_pkg::OP_BIT) begin
      st[alu8_pkg::FlagZ] = ((a & m) == 8'd0);
      st[alu8_pkg::FlagV] = m[6];
      st[alu8_pkg::FlagN] = m[7];
    end else if (wr) begin
      st[alu8_pkg::FlagZ] = (r == 8'd0);
      st[alu8_pkg::FlagN] = r[7];
    end

    res_d.result       = r;
    res_d.result_write = wr;
    res_d.status_out   = st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= accept;
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= item_i;
    end
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ src/alu8_checker.sv @@
// Port-level checker for the eight-bit ALU, bound to the top level.
module alu8_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input alu8_pkg::alu_in_t  item_i,
  input logic               res_valid_o,
  input alu8_pkg::alu_out_t res_o
);

  // every result strobe traces back to a command transfer, through the input and result valid registers
  a_res_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start & ~busy, 2))
    else $error("result strobe without a command transfer");

  // compare, BIT and undefined codes produce a zero byte
  a_nowrite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.result_write) |-> (res_o.result == 8'd0))
    else $error("non-written result is not zero");

  // B, D, I and bit 5 pass through untouched
  a_status_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.status_out[5:2] == $past(item_i.status_in[5:2], 2)))
    else $error("pass-through status bits altered");

  // load returns the memory operand and writes it back
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && ($past(item_i.operation, 2) == alu8_pkg::OP_LOAD)) |->
      (res_o.result_write && (res_o.result == $past(item_i.mem_value, 2))))
    else $error("load result mismatch");

endmodule

bind eight_bit_alu_with_flags alu8_checker u_alu8_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .item_i      (item_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
